>>> hw/rtl/ifmd_pkg.sv
// ----------------------------------------------------------------------------
// ifmd_pkg
// Shared types and constants of the mass dissimilarity forest core.
// ----------------------------------------------------------------------------
`default_nettype none

package ifmd_pkg;

    localparam logic [1:0] CMD_NODE  = 2'd0;
    localparam logic [1:0] CMD_ATTR  = 2'd1;
    localparam logic [1:0] CMD_ROUTE = 2'd2;
    localparam logic [1:0] CMD_QUERY = 2'd3;

    localparam int          MASS_W   = 11;
    localparam int          SIZE_W   = 11;
    localparam int          SATTR_W  = 4;
    localparam int          HGT_W    = 4;
    localparam int          SUM_W    = 16;
    localparam logic [10:0] MASS_MAX = 11'd2047;

    localparam logic [1:0] REG_TREE_COUNT  = 2'd0;
    localparam logic [1:0] REG_TREE_HEIGHT = 2'd1;

    typedef struct packed {
        logic [1:0]         command;
        logic [4:0]         tree;
        logic [8:0]         node;
        logic [3:0]         attribute;
        logic signed [31:0] value;
        logic [10:0]        node_size;
        logic [9:0]         instance_req;
        logic [9:0]         other_instance;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] mass_sum;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic item_load;
        logic clr_en;
        logic node_wr;
        logic attr_wr;
        logic start;
        logic rt_eval;
        logic rt_step;
        logic next_tree;
        logic sel_b;
        logic cap_a;
        logic cap_b;
        logic anc_step;
        logic q_add;
        logic out_load;
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       clr_last;
        logic       node_ok;
        logic       attr_ok;
        logic       inst_ok;
        logic       no_trees;
        logic       size_zero;
        logic       leaf_stop;
        logic       last_tree;
        logic       anc_equal;
    } stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/ifmd_ram.sv
// ----------------------------------------------------------------------------
// ifmd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ifmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/ifmd_ctrl.sv
// ----------------------------------------------------------------------------
// ifmd_ctrl
// Sequencer for clearing, loads, routing walks and ancestor queries.
// ----------------------------------------------------------------------------
`default_nettype none

module ifmd_ctrl
    import ifmd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    output logic       item_stall,
    output logic       result_valid,
    input  wire logic  result_stall,
    input  wire stat_t stat,
    output ctrl_t      ctrl,
    output logic       busy_clr
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DEC  = 4'd2;
    localparam logic [3:0] S_RRD  = 4'd3;
    localparam logic [3:0] S_REV  = 4'd4;
    localparam logic [3:0] S_RCMP = 4'd5;
    localparam logic [3:0] S_QRA  = 4'd6;
    localparam logic [3:0] S_QRB  = 4'd7;
    localparam logic [3:0] S_QLB  = 4'd8;
    localparam logic [3:0] S_QANC = 4'd9;
    localparam logic [3:0] S_QADD = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       valid_reg, valid_next;

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            S_CLR:
            begin
                ctrl.clr_en = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    ctrl.item_load = 1'b1;
                    state_next     = S_DEC;
                end
            end
            S_DEC:
            begin
                ctrl.start = 1'b1;
                state_next = S_DONE;
                case (stat.cmd)
                    CMD_NODE:  ctrl.node_wr = stat.node_ok;
                    CMD_ATTR:  ctrl.attr_wr = stat.attr_ok;
                    CMD_ROUTE:
                    begin
                        if (stat.inst_ok && !stat.no_trees)
                        begin
                            state_next = S_RRD;
                        end
                    end
                    default:
                    begin
                        if (!stat.no_trees)
                        begin
                            state_next = S_QRA;
                        end
                    end
                endcase
            end
            S_RRD:
            begin
                state_next = S_REV;
            end
            S_REV:
            begin
                ctrl.rt_eval = 1'b1;
                if (stat.size_zero || stat.leaf_stop)
                begin
                    ctrl.next_tree = 1'b1;
                    state_next     = stat.last_tree ? S_DONE : S_RRD;
                end
                else
                begin
                    state_next = S_RCMP;
                end
            end
            S_RCMP:
            begin
                ctrl.rt_step = 1'b1;
                state_next   = S_RRD;
            end
            S_QRA:
            begin
                state_next = S_QRB;
            end
            S_QRB:
            begin
                ctrl.cap_a = 1'b1;
                ctrl.sel_b = 1'b1;
                state_next = S_QLB;
            end
            S_QLB:
            begin
                ctrl.cap_b = 1'b1;
                state_next = S_QANC;
            end
            S_QANC:
            begin
                if (stat.anc_equal)
                begin
                    state_next = S_QADD;
                end
                else
                begin
                    ctrl.anc_step = 1'b1;
                end
            end
            S_QADD:
            begin
                ctrl.q_add     = 1'b1;
                ctrl.next_tree = 1'b1;
                state_next     = stat.last_tree ? S_DONE : S_QRA;
            end
            S_DONE:
            begin
                if (!valid_reg || !result_stall)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (valid_reg && !result_stall)
        begin
            valid_next = 1'b0;
        end
        if (ctrl.out_load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = valid_reg;
    assign busy_clr     = (state_reg == S_CLR);

endmodule

`default_nettype wire

>>> hw/rtl/ifmd_dp.sv
// ----------------------------------------------------------------------------
// ifmd_dp
// Datapath: node, attribute, mass and leaf memories, walk and ancestor logic.
// ----------------------------------------------------------------------------
`default_nettype none

module ifmd_dp
    import ifmd_pkg::*;
#(
    parameter int MAX_TREES     = 32,
    parameter int TREE_DEPTH    = 8,
    parameter int MAX_INSTANCES = 1024,
    parameter int MAX_ATTRS     = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire item_t      item,
    input  wire logic [5:0] tree_count,
    input  wire logic [3:0] tree_height,
    input  wire ctrl_t      ctrl,
    output stat_t           stat,
    output result_t         result
);

    localparam int TW         = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
    localparam int NW         = TREE_DEPTH + 1;
    localparam int IW         = $clog2(MAX_INSTANCES);
    localparam int AW         = (MAX_ATTRS > 1) ? $clog2(MAX_ATTRS) : 1;
    localparam int NODES      = (2 ** NW) - 1;
    localparam int NODE_DEPTH = MAX_TREES * (2 ** NW);
    localparam int LEAF_DEPTH = MAX_INSTANCES * (2 ** TW);
    localparam int ATTR_DEPTH = MAX_INSTANCES * (2 ** AW);
    localparam int NAW        = $clog2(NODE_DEPTH);
    localparam int LAW        = $clog2(LEAF_DEPTH);
    localparam int ATW        = $clog2(ATTR_DEPTH);
    localparam int CLR_COUNT  = (NODE_DEPTH > LEAF_DEPTH) ? NODE_DEPTH : LEAF_DEPTH;
    localparam int CW         = $clog2(CLR_COUNT) + 1;
    localparam int NDW        = SATTR_W + 32 + SIZE_W;

    item_t              item_reg;
    logic [TW-1:0]      t_reg;
    logic [NW-1:0]      node_reg;
    logic [NW-1:0]      lb_reg;
    logic [HGT_W-1:0]   h_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [CW-1:0]      clr_reg;
    result_t            result_reg;

    logic [31:0]        tree_x, node_x, attr_x, inst_x, other_x, tc_x, sattr_x;
    logic [TW:0]        used;
    logic [HGT_W-1:0]   limit;
    logic [NDW-1:0]     nd_wdata, nd_rdata;
    logic [SATTR_W-1:0] s_attr;
    logic signed [31:0] s_point;
    logic [SIZE_W-1:0]  s_size;
    logic [MASS_W-1:0]  mass_rdata, mass_wdata;
    logic [NAW-1:0]     mass_waddr;
    logic               mass_we;
    logic [NW-1:0]      leaf_rdata, leaf_wdata;
    logic [LAW-1:0]     leaf_waddr, leaf_raddr;
    logic               leaf_we;
    logic [31:0]        attr_rdata;
    logic signed [31:0] attr_val;
    logic [31:0]        sel_inst;
    logic               a_ok;
    logic               b_ok;
    logic               go_left;

    assign tree_x  = 32'(item_reg.tree);
    assign node_x  = 32'(item_reg.node);
    assign attr_x  = 32'(item_reg.attribute);
    assign inst_x  = 32'(item_reg.instance_req);
    assign other_x = 32'(item_reg.other_instance);
    assign tc_x    = 32'(tree_count);
    assign used    = (tc_x > 32'(MAX_TREES)) ? (TW+1)'(MAX_TREES) : (TW+1)'(tc_x);
    assign limit   = (32'(tree_height) > 32'(TREE_DEPTH)) ? HGT_W'(TREE_DEPTH) : tree_height;

    assign {s_attr, s_point, s_size} = nd_rdata;
    assign sattr_x  = 32'(s_attr);
    assign nd_wdata = {item_reg.attribute, item_reg.value, item_reg.node_size};

    ifmd_ram #(.WIDTH(NDW), .DEPTH(NODE_DEPTH)) u_node_ram (
        .clk   (clk),
        .we    (ctrl.node_wr),
        .waddr ({tree_x[TW-1:0], node_x[NW-1:0]}),
        .wdata (nd_wdata),
        .raddr ({t_reg, node_reg}),
        .rdata (nd_rdata)
    );

    ifmd_ram #(.WIDTH(32), .DEPTH(ATTR_DEPTH)) u_attr_ram (
        .clk   (clk),
        .we    (ctrl.attr_wr),
        .waddr (ATW'({inst_x[IW-1:0], attr_x[AW-1:0]})),
        .wdata (item_reg.value),
        .raddr (ATW'({inst_x[IW-1:0], sattr_x[AW-1:0]})),
        .rdata (attr_rdata)
    );

    // saturating mass count, or zero fill after reset
    always_comb
    begin
        mass_we    = 1'b0;
        mass_waddr = {t_reg, node_reg};
        mass_wdata = (mass_rdata < MASS_MAX) ? mass_rdata + MASS_W'(1) : mass_rdata;
        if (ctrl.clr_en)
        begin
            mass_we    = (32'(clr_reg) < 32'(NODE_DEPTH));
            mass_waddr = clr_reg[NAW-1:0];
            mass_wdata = '0;
        end
        else if (ctrl.rt_eval && !stat.size_zero)
        begin
            mass_we = 1'b1;
        end
    end

    ifmd_ram #(.WIDTH(MASS_W), .DEPTH(NODE_DEPTH)) u_mass_ram (
        .clk   (clk),
        .we    (mass_we),
        .waddr (mass_waddr),
        .wdata (mass_wdata),
        .raddr ({t_reg, node_reg}),
        .rdata (mass_rdata)
    );

    assign sel_inst   = ctrl.sel_b ? other_x : inst_x;
    assign leaf_raddr = {sel_inst[IW-1:0], t_reg};

    always_comb
    begin
        leaf_we    = 1'b0;
        leaf_waddr = {inst_x[IW-1:0], t_reg};
        leaf_wdata = stat.size_zero ? '0 : node_reg;
        if (ctrl.clr_en)
        begin
            leaf_we    = (32'(clr_reg) < 32'(LEAF_DEPTH));
            leaf_waddr = clr_reg[LAW-1:0];
            leaf_wdata = '0;
        end
        else if (ctrl.rt_eval && (stat.size_zero || stat.leaf_stop))
        begin
            leaf_we = 1'b1;
        end
    end

    ifmd_ram #(.WIDTH(NW), .DEPTH(LEAF_DEPTH)) u_leaf_ram (
        .clk   (clk),
        .we    (leaf_we),
        .waddr (leaf_waddr),
        .wdata (leaf_wdata),
        .raddr (leaf_raddr),
        .rdata (leaf_rdata)
    );

    // split attributes past the table read as zero
    assign attr_val = (sattr_x < 32'(MAX_ATTRS)) ? $signed(attr_rdata) : 32'sd0;
    assign go_left  = (attr_val < s_point);
    assign a_ok     = (inst_x < 32'(MAX_INSTANCES));
    assign b_ok     = (other_x < 32'(MAX_INSTANCES));

    always_ff @(posedge clk)
    begin
        if (ctrl.item_load)
        begin
            item_reg <= item;
        end
        if (ctrl.out_load)
        begin
            result_reg.kind     <= item_reg.command;
            result_reg.mass_sum <= sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg    <= '0;
            node_reg <= '0;
            lb_reg   <= '0;
            h_reg    <= '0;
            sum_reg  <= '0;
            clr_reg  <= '0;
        end
        else
        begin
            if (ctrl.clr_en)
            begin
                clr_reg <= clr_reg + CW'(1);
            end
            if (ctrl.start)
            begin
                t_reg    <= '0;
                node_reg <= '0;
                h_reg    <= '0;
                sum_reg  <= '0;
            end
            if (ctrl.next_tree)
            begin
                t_reg    <= t_reg + TW'(1);
                node_reg <= '0;
                h_reg    <= '0;
            end
            if (ctrl.rt_step)
            begin
                node_reg <= {node_reg[NW-2:0], 1'b0} + (go_left ? NW'(1) : NW'(2));
                h_reg    <= h_reg + HGT_W'(1);
            end
            if (ctrl.cap_a)
            begin
                node_reg <= a_ok ? leaf_rdata : '0;
            end
            if (ctrl.cap_b)
            begin
                lb_reg <= b_ok ? leaf_rdata : '0;
            end
            // climb from the deeper of the two heap indexes
            if (ctrl.anc_step)
            begin
                if (node_reg > lb_reg)
                begin
                    node_reg <= (node_reg - NW'(1)) >> 1;
                end
                else
                begin
                    lb_reg <= (lb_reg - NW'(1)) >> 1;
                end
            end
            if (ctrl.q_add)
            begin
                sum_reg <= sum_reg + SUM_W'(mass_rdata);
            end
        end
    end

    always_comb
    begin
        stat.cmd       = item_reg.command;
        stat.clr_last  = (32'(clr_reg) == 32'(CLR_COUNT - 1));
        stat.node_ok   = (tree_x < 32'(MAX_TREES)) && (node_x < 32'(NODES));
        stat.attr_ok   = (inst_x < 32'(MAX_INSTANCES)) && (attr_x < 32'(MAX_ATTRS));
        stat.inst_ok   = (inst_x < 32'(MAX_INSTANCES));
        stat.no_trees  = (used == '0);
        stat.size_zero = (s_size == '0);
        stat.leaf_stop = (s_size == SIZE_W'(1)) || (h_reg >= limit);
        stat.last_tree = (({1'b0, t_reg} + (TW+1)'(1)) == used);
        stat.anc_equal = (node_reg == lb_reg);
    end

    assign result = result_reg;

endmodule

`default_nettype wire

>>> hw/rtl/isolation_forest_mass_dissimilarity_core.sv
// ----------------------------------------------------------------------------
// isolation_forest_mass_dissimilarity_core
// Isolation forest store with instance routing and mass dissimilarity query.
// ----------------------------------------------------------------------------
// One item is handled at a time. A node or attribute load is written in the
// decode state. A route reads and evaluates each node of a tree, stepping down
// one split level at a time until it ends at a leaf, for every tree in use. A
// query reads the leaves of both instances in each tree, climbs one ancestor
// step at a time until they meet and adds the mass of that common node.
// After reset a clearing pass zeroes the mass and leaf memories while no item
// is accepted; register writes still work.
// A finished result waits in an output register while the next item enters.
`default_nettype none

module isolation_forest_mass_dissimilarity_core
    import ifmd_pkg::*;
#(
    parameter int MAX_TREES     = 32,
    parameter int TREE_DEPTH    = 8,
    parameter int MAX_INSTANCES = 1024,
    parameter int MAX_ATTRS     = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire item_t       item,
    output logic             result_valid,
    input  wire logic        result_stall,
    output result_t          result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [5:0] tree_count_reg;
    logic [3:0] tree_height_reg;
    logic [1:0] reg_index;
    ctrl_t      ctrl;
    stat_t      stat;
    logic       busy_clr;

    assign pready    = 1'b1;
    assign reg_index = {1'b0, paddr[2]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tree_count_reg  <= 6'd1;
            tree_height_reg <= 4'd8;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_index)
                REG_TREE_COUNT:  tree_count_reg  <= pwdata[5:0];
                REG_TREE_HEIGHT: tree_height_reg <= pwdata[3:0];
                default:         tree_count_reg  <= tree_count_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_TREE_COUNT:  prdata = {26'd0, tree_count_reg};
            REG_TREE_HEIGHT: prdata = {28'd0, tree_height_reg};
            default:         prdata = '0;
        endcase
    end

    ifmd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .ctrl         (ctrl),
        .busy_clr     (busy_clr)
    );

    ifmd_dp #(
        .MAX_TREES     (MAX_TREES),
        .TREE_DEPTH    (TREE_DEPTH),
        .MAX_INSTANCES (MAX_INSTANCES),
        .MAX_ATTRS     (MAX_ATTRS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .tree_count  (tree_count_reg),
        .tree_height (tree_height_reg),
        .ctrl        (ctrl),
        .stat        (stat),
        .result      (result)
    );

    a_clr_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        busy_clr |-> item_stall)
        else $error("item taken during clearing pass");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("second item taken before first finished");

    a_sum_only_query: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.kind != CMD_QUERY)) |-> (result.mass_sum == 16'd0))
        else $error("nonzero mass on non-query result");

endmodule

`default_nettype wire

>>> verif/isolation_forest_mass_dissimilarity_core_tb.sv
// ----------------------------------------------------------------------------
// isolation_forest_mass_dissimilarity_core_tb
// Self-checking bench: builds small forests, loads instance attributes, routes
// instances and queries pairs while predicting node masses, leaves and the
// summed ancestor mass. Registers are changed between phases over APB.
// ----------------------------------------------------------------------------
module isolation_forest_mass_dissimilarity_core_tb;
    import ifmd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTREES     = 32;
    localparam int DEPTH      = 8;
    localparam int NINST      = 1024;
    localparam int NATTR      = 16;
    localparam int NNODES     = (2 << DEPTH) - 1;
    localparam int LIMIT      = 3000000;
    localparam int DEEP_TREES = 4;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    item_t       item;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    isolation_forest_mass_dissimilarity_core DUT (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [31:0] inst_attr [NINST*NATTR];
    logic [3:0]  node_attr [NTREES*NNODES];
    logic [31:0] node_split [NTREES*NNODES];
    logic [10:0] node_cnt [NTREES*NNODES];
    logic [10:0] node_mass [NTREES*NNODES];
    logic [8:0]  inst_leaf [NINST*NTREES];
    logic [5:0]  cfg_trees;
    logic [3:0]  cfg_height;

    item_t   pending_items[$];
    result_t expected_results[$];
    int      errors;
    int      cycles;
    bit      calm;
    int      gap_left;
    int      stall_left;

    // stimulus bookkeeping so nothing unwritten is ever read
    bit      attrs_full [NINST];
    int      ready_insts[$];
    int      routed_insts[$];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = 1'b1;
            #10 clk = 1'b0;
        end
    end

    function automatic int common_node(int a, int b);
        while (a != b)
        begin
            if (a > b) a = (a - 1) >> 1;
            else       b = (b - 1) >> 1;
        end
        return a;
    endfunction

    function automatic result_t forest_step(item_t it);
        result_t r;
        int      trees;
        int      lim;
        int      n;
        int      h;
        int      k;
        int      la;
        int      lb;
        logic [31:0] v;
        logic [31:0] sum;
        trees = (cfg_trees > NTREES) ? NTREES : cfg_trees;
        lim   = (cfg_height > DEPTH) ? DEPTH : cfg_height;
        sum   = 0;
        case (it.command)
            CMD_NODE:
                if (it.tree < NTREES && it.node < NNODES)
                begin
                    k = it.tree * NNODES + it.node;
                    node_attr[k]  = it.attribute;
                    node_split[k] = it.value;
                    node_cnt[k]   = it.node_size;
                end
            CMD_ATTR:
                if (it.instance_req < NINST && it.attribute < NATTR)
                    inst_attr[it.instance_req*NATTR + it.attribute] = it.value;
            CMD_ROUTE:
                if (it.instance_req < NINST)
                    for (int t = 0; t < trees; t++)
                    begin
                        n = 0;
                        h = 0;
                        forever
                        begin
                            k = t * NNODES + n;
                            if (node_cnt[k] == 0)
                            begin
                                inst_leaf[it.instance_req*NTREES + t] = '0;
                                break;
                            end
                            if (node_mass[k] < MASS_MAX) node_mass[k]++;
                            if (node_cnt[k] == 1 || h >= lim)
                            begin
                                inst_leaf[it.instance_req*NTREES + t] = 9'(n);
                                break;
                            end
                            v = (node_attr[k] < NATTR) ?
                                inst_attr[it.instance_req*NATTR + node_attr[k]] : 32'd0;
                            n = ($signed(v) < $signed(node_split[k])) ? 2*n + 1 : 2*n + 2;
                            h++;
                        end
                    end
            default:
                for (int t = 0; t < trees; t++)
                begin
                    la = (it.instance_req < NINST) ? inst_leaf[it.instance_req*NTREES + t] : 0;
                    lb = (it.other_instance < NINST) ?
                         inst_leaf[it.other_instance*NTREES + t] : 0;
                    sum += node_mass[t*NNODES + common_node(la, lb)];
                end
        endcase
        r.kind     = it.command;
        r.mass_sum = sum[15:0];
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
            gap_left   <= 0;
        end
        else if (!item_valid || !item_stall)
        begin
            if (gap_left > 0)
            begin
                gap_left   <= gap_left - 1;
                item_valid <= 1'b0;
            end
            else if (pending_items.size() > 0 && !calm && $urandom_range(0, 7) == 0)
            begin
                gap_left   <= $urandom_range(0, 3);
                item_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                item       <= pending_items[0];
                item_valid <= 1'b1;
                expected_results = {expected_results, forest_step(pending_items[0])};
                pending_items.delete(0);
            end
            else
                item_valid <= 1'b0;
        end
    end

    // monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left   <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result kind=%0d mass_sum=%0d",
                             $time, result.kind, result.mass_sum);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.kind !== want.kind)
                    begin
                        $display("%0t: kind expected %0d actual %0d",
                                 $time, want.kind, result.kind);
                        errors++;
                    end
                    if (result.mass_sum !== want.mass_sum)
                    begin
                        $display("%0t: mass_sum expected %0d actual %0d",
                                 $time, want.mass_sum, result.mass_sum);
                        errors++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left   <= stall_left - 1;
                result_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall_left   <= $urandom_range(0, 3);
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx[0], 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_TREE_COUNT) cfg_trees = data[5:0];
        else                       cfg_height = data[3:0];
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && expected_results.size() == 0);
        @(posedge clk);
    endtask

    function automatic item_t blank_item(logic [1:0] cmd);
        item_t it;
        it = '0;
        it.command        = cmd;
        it.tree           = 5'($urandom);
        it.node           = 9'($urandom);
        it.attribute      = 4'($urandom);
        it.value          = $urandom;
        it.node_size      = 11'($urandom);
        it.instance_req   = 10'($urandom);
        it.other_instance = 10'($urandom);
        return it;
    endfunction

    // deep trees hold three levels, the rest a root only; the lowest written
    // level always ends the walk so no unwritten node is reached
    function automatic bit is_bottom(int t, int n);
        return (t >= DEEP_TREES) || (n >= 3);
    endfunction

    function automatic item_t forest_node(int t, int n);
        item_t it;
        it = blank_item(CMD_NODE);
        it.tree      = 5'(t);
        it.node      = 9'(n);
        it.value     = $signed($urandom_range(0, 8)) * 32'sh4000 - 32'sh10000;
        it.attribute = ($urandom_range(0, 19) == 0) ? 4'd15 : 4'($urandom_range(0, 3));
        if (is_bottom(t, n))
            it.node_size = 11'($urandom_range(0, 1));
        else
            case ($urandom_range(0, 9))
                0:       it.node_size = (n == 0) ? 11'd1024 : 11'd0;
                1:       it.node_size = 11'd1;
                2:       it.node_size = 11'd1024;
                default: it.node_size = 11'($urandom_range(2, 300));
            endcase
        return it;
    endfunction

    task automatic build_forest();
        int top;
        for (int t = 0; t < NTREES; t++)
        begin
            top = (t < DEEP_TREES) ? 7 : 1;
            for (int n = 0; n < top; n++)
                pending_items = {pending_items, forest_node(t, n)};
        end
    endtask

    task automatic load_instance(int inst);
        item_t it;
        for (int a = 0; a < NATTR; a++)
        begin
            it = blank_item(CMD_ATTR);
            it.instance_req = 10'(inst);
            it.attribute    = 4'(a);
            it.value        = $signed($urandom_range(0, 8)) * 32'sh4000 - 32'sh10000;
            if ($urandom_range(0, 9) == 0) it.value = $urandom;
            pending_items = {pending_items, it};
        end
        if (!attrs_full[inst]) ready_insts = {ready_insts, inst};
        attrs_full[inst] = 1'b1;
    endtask

    function automatic item_t pick(logic [1:0] cmd);
        item_t it;
        it = blank_item(cmd);
        if (cmd == CMD_ROUTE)
        begin
            if ($urandom_range(0, 9) == 0) it.instance_req = 10'd1023;
            else it.instance_req = 10'(ready_insts[$urandom_range(0, ready_insts.size()-1)]);
            routed_insts = {routed_insts, int'(it.instance_req)};
        end
        else if (cmd == CMD_QUERY && routed_insts.size() > 0)
        begin
            if ($urandom_range(0, 7) != 0)
                it.instance_req =
                    10'(routed_insts[$urandom_range(0, routed_insts.size()-1)]);
            if ($urandom_range(0, 7) != 0)
                it.other_instance =
                    10'(routed_insts[$urandom_range(0, routed_insts.size()-1)]);
        end
        return it;
    endfunction

    initial
    begin
        item_t it;
        int    pick_cmd;
        int    nt;
        errors       = 0;
        cycles       = 0;
        calm         = 0;
        cfg_trees    = 1;
        cfg_height   = 8;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        for (int i = 0; i < NTREES*NNODES; i++) node_mass[i] = '0;
        for (int i = 0; i < NINST*NTREES; i++) inst_leaf[i] = '0;
        for (int i = 0; i < NINST; i++) attrs_full[i] = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: queries on fresh state, out-of-range loads, extremes
        it = blank_item(CMD_QUERY);
        it.instance_req = 0; it.other_instance = 10'd1023;
        pending_items = {pending_items, it};
        it = blank_item(CMD_NODE); // node beyond heap is ignored
        it.node = 9'd511;
        pending_items = {pending_items, it};
        build_forest();
        it = blank_item(CMD_ATTR); // attribute load to the top instance, later overwritten
        it.instance_req = 10'd1023;
        pending_items = {pending_items, it};
        load_instance(0);
        load_instance(1023);
        load_instance(5);
        it = blank_item(CMD_ROUTE); it.instance_req = 0;    pending_items = {pending_items, it};
        it = blank_item(CMD_ROUTE); it.instance_req = 1023; pending_items = {pending_items, it};
        it = blank_item(CMD_ROUTE); it.instance_req = 0;    pending_items = {pending_items, it};
        routed_insts = {routed_insts, 0};
        routed_insts = {routed_insts, 1023};
        it = blank_item(CMD_QUERY); it.instance_req = 0; it.other_instance = 1023;
        pending_items = {pending_items, it};
        it = blank_item(CMD_QUERY); it.instance_req = 5; it.other_instance = 5;
        pending_items = {pending_items, it};
        drain();

        // phases through register settings, extremes included
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin reg_write(REG_TREE_COUNT, 32); reg_write(REG_TREE_HEIGHT, 8); end
                1: begin reg_write(REG_TREE_COUNT, 0);  reg_write(REG_TREE_HEIGHT, 0); end
                2: begin reg_write(REG_TREE_COUNT, 63); reg_write(REG_TREE_HEIGHT, 15); end
                3: begin reg_write(REG_TREE_COUNT, 1);  reg_write(REG_TREE_HEIGHT, 1); end
                4: begin reg_write(REG_TREE_COUNT, $urandom_range(1, 32));
                          reg_write(REG_TREE_HEIGHT, $urandom_range(1, 8)); end
                default: begin reg_write(REG_TREE_COUNT, 8); reg_write(REG_TREE_HEIGHT, 4);
                          calm = 1; end
            endcase
            load_instance($urandom_range(1, 1022));
            for (int j = 0; j < 40; j++)
            begin
                pick_cmd = $urandom_range(0, 9);
                if (pick_cmd < 4)      it = pick(CMD_ROUTE);
                else if (pick_cmd < 8) it = pick(CMD_QUERY);
                else if (pick_cmd < 9)
                begin
                    it = blank_item(CMD_ATTR);
                    it.instance_req =
                        10'(ready_insts[$urandom_range(0, ready_insts.size()-1)]);
                end
                else if ($urandom_range(0, 4) == 0)
                begin
                    it = blank_item(CMD_NODE);
                    it.node = 9'd511;
                end
                else
                begin
                    nt = $urandom_range(0, NTREES-1);
                    it = forest_node(nt, (nt < DEEP_TREES) ? $urandom_range(0, 6) : 0);
                end
                pending_items = {pending_items, it};
                if (j == 20) drain(); // sender holds off until results catch up
            end
            drain();
        end

        repeat (1000) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
